// ===== hdl/strip_triangulate_two_curves_unit_assert.svh =====
// assertion macros for the strip triangulation unit
`ifndef STRIP_TRIANGULATE_TWO_CURVES_UNIT_ASSERT_SVH
`define STRIP_TRIANGULATE_TWO_CURVES_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define STC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stc assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define STC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stc assertion failed");

`endif

// ===== hdl/stc_pkg.sv =====
// shared types, constants and micro-op table of the strip triangulation unit
`timescale 1ns / 1ps

package stc_pkg;

    localparam int MAX_POINTS_DEF  = 32;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int TAG_WIDTH_DEF   = 16;

    localparam int MODE_W        = 2;
    localparam int TAG_FIELD_W   = 16;
    localparam int COORD_FIELD_W = 24;
    localparam int IN_DATA_W     = TAG_FIELD_W + 2 * COORD_FIELD_W;
    localparam int OUT_DATA_W    = 3 * TAG_FIELD_W;

    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

    // point slots held by the sequencer
    localparam logic [1:0] PT_A = 2'd0;
    localparam logic [1:0] PT_B = 2'd1;
    localparam logic [1:0] PT_C = 2'd2;
    localparam logic [1:0] PT_D = 2'd3;
    localparam int PT_N = 4;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    localparam logic [1:0] ACC_LOAD = 2'd0;
    localparam logic [1:0] ACC_ADD  = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;

    localparam int FLAG_N = 5;
    localparam logic [2:0] FLAG_DLT = 3'd0;
    localparam logic [2:0] FLAG_ADC = 3'd1;
    localparam logic [2:0] FLAG_CBD = 3'd2;
    localparam logic [2:0] FLAG_ABD = 3'd3;
    localparam logic [2:0] FLAG_ABC = 3'd4;

    localparam int OP_COUNT = 12;
    localparam int UNIT_LAT = 3;
    localparam int OP_CNT_W = $clog2(OP_COUNT + UNIT_LAT);

    typedef struct packed {
        logic [1:0] a_hi;
        logic [1:0] a_lo;
        logic       a_axis;
        logic [1:0] b_hi;
        logic [1:0] b_lo;
        logic       b_axis;
        logic [1:0] acc_op;
        logic       cap;
        logic [2:0] flag;
    } t_uop;

    // sign flags, member order matches the flag codes from the top bit down
    typedef struct packed {
        logic abc;
        logic abd;
        logic cbd;
        logic adc;
        logic dlt;
    } t_orient;

    function automatic t_uop mk_uop(
        input logic [1:0] a_hi, input logic [1:0] a_lo, input logic a_axis,
        input logic [1:0] b_hi, input logic [1:0] b_lo, input logic b_axis,
        input logic [1:0] acc_op, input logic cap, input logic [2:0] flag);
        t_uop u;
        u.a_hi   = a_hi;
        u.a_lo   = a_lo;
        u.a_axis = a_axis;
        u.b_hi   = b_hi;
        u.b_lo   = b_lo;
        u.b_axis = b_axis;
        u.acc_op = acc_op;
        u.cap    = cap;
        u.flag   = flag;
        return u;
    endfunction

    // one product (a_hi - a_lo) * (b_hi - b_lo) per step, folded into the accumulator
    function automatic t_uop uop_rom(input logic [OP_CNT_W-1:0] k);
        t_uop u;
        u = mk_uop(PT_A, PT_A, AXIS_X, PT_A, PT_A, AXIS_X, ACC_LOAD, 1'b0, FLAG_DLT);
        case (k)
            OP_CNT_W'(0):  u = mk_uop(PT_B, PT_A, AXIS_X, PT_C, PT_A, AXIS_Y,
                                      ACC_LOAD, 1'b0, FLAG_ABC);
            OP_CNT_W'(1):  u = mk_uop(PT_B, PT_A, AXIS_Y, PT_C, PT_A, AXIS_X,
                                      ACC_SUB, 1'b1, FLAG_ABC);
            OP_CNT_W'(2):  u = mk_uop(PT_B, PT_A, AXIS_X, PT_D, PT_A, AXIS_Y,
                                      ACC_LOAD, 1'b0, FLAG_ABD);
            OP_CNT_W'(3):  u = mk_uop(PT_B, PT_A, AXIS_Y, PT_D, PT_A, AXIS_X,
                                      ACC_SUB, 1'b1, FLAG_ABD);
            OP_CNT_W'(4):  u = mk_uop(PT_B, PT_C, AXIS_X, PT_D, PT_C, AXIS_Y,
                                      ACC_LOAD, 1'b0, FLAG_CBD);
            OP_CNT_W'(5):  u = mk_uop(PT_B, PT_C, AXIS_Y, PT_D, PT_C, AXIS_X,
                                      ACC_SUB, 1'b1, FLAG_CBD);
            OP_CNT_W'(6):  u = mk_uop(PT_D, PT_A, AXIS_X, PT_C, PT_A, AXIS_Y,
                                      ACC_LOAD, 1'b0, FLAG_ADC);
            OP_CNT_W'(7):  u = mk_uop(PT_D, PT_A, AXIS_Y, PT_C, PT_A, AXIS_X,
                                      ACC_SUB, 1'b1, FLAG_ADC);
            OP_CNT_W'(8):  u = mk_uop(PT_C, PT_B, AXIS_X, PT_C, PT_B, AXIS_X,
                                      ACC_LOAD, 1'b0, FLAG_DLT);
            OP_CNT_W'(9):  u = mk_uop(PT_C, PT_B, AXIS_Y, PT_C, PT_B, AXIS_Y,
                                      ACC_ADD, 1'b0, FLAG_DLT);
            OP_CNT_W'(10): u = mk_uop(PT_D, PT_A, AXIS_X, PT_D, PT_A, AXIS_X,
                                      ACC_SUB, 1'b0, FLAG_DLT);
            OP_CNT_W'(11): u = mk_uop(PT_D, PT_A, AXIS_Y, PT_D, PT_A, AXIS_Y,
                                      ACC_SUB, 1'b1, FLAG_DLT);
            default: ;
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/stc_point_ram.sv =====
// point store of one curve, one write port and one registered read port
`timescale 1ns / 1ps

module stc_point_ram #(
    parameter int DEPTH  = stc_pkg::MAX_POINTS_DEF,
    parameter int ADDR_W = $clog2(stc_pkg::MAX_POINTS_DEF),
    parameter int DATA_W = stc_pkg::TAG_WIDTH_DEF + 2 * stc_pkg::COORD_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/stc_area_unit.sv =====
// shared difference, multiply and accumulate unit for orientation and distance tests
`timescale 1ns / 1ps

module stc_area_unit #(
    parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [stc_pkg::PT_N-1:0][COORD_WIDTH-1:0] i_px,
    input  logic [stc_pkg::PT_N-1:0][COORD_WIDTH-1:0] i_py,
    input  logic                                     i_uop_valid,
    input  stc_pkg::t_uop                            i_uop,
    output stc_pkg::t_orient                         o_flags
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = PROD_W + 2;

    logic signed [COORD_WIDTH-1:0] a_hi_v;
    logic signed [COORD_WIDTH-1:0] a_lo_v;
    logic signed [COORD_WIDTH-1:0] b_hi_v;
    logic signed [COORD_WIDTH-1:0] b_lo_v;

    logic                 r_v1;
    logic                 r_v2;
    stc_pkg::t_uop        r_uop1;
    stc_pkg::t_uop        r_uop2;
    logic signed [DIFF_W-1:0] r_da;
    logic signed [DIFF_W-1:0] r_db;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic [stc_pkg::FLAG_N-1:0] r_flag;

    assign a_hi_v = i_uop.a_axis ? i_py[i_uop.a_hi] : i_px[i_uop.a_hi];
    assign a_lo_v = i_uop.a_axis ? i_py[i_uop.a_lo] : i_px[i_uop.a_lo];
    assign b_hi_v = i_uop.b_axis ? i_py[i_uop.b_hi] : i_px[i_uop.b_hi];
    assign b_lo_v = i_uop.b_axis ? i_py[i_uop.b_lo] : i_px[i_uop.b_lo];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_uop_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_uop1 <= i_uop;
        r_da   <= DIFF_W'(a_hi_v) - DIFF_W'(a_lo_v);
        r_db   <= DIFF_W'(b_hi_v) - DIFF_W'(b_lo_v);
        r_uop2 <= r_uop1;
        r_prod <= r_da * r_db;
    end

    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        case (r_uop2.acc_op)
            stc_pkg::ACC_LOAD: n_acc = prod_ext;
            stc_pkg::ACC_ADD:  n_acc = r_acc + prod_ext;
            stc_pkg::ACC_SUB:  n_acc = r_acc - prod_ext;
            default:           n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc <= n_acc;
            if (r_uop2.cap) begin
                r_flag[r_uop2.flag] <= n_acc[ACC_W-1];
            end
        end
    end

    assign o_flags = stc_pkg::t_orient'(r_flag);

endmodule

// ===== hdl/strip_triangulate_two_curves_unit.sv =====
// top level of the two-curve strip triangulation unit
`timescale 1ns / 1ps

// Load commands (tuser 0 for curve A, 1 for curve B) each store a point; a
// load into a full curve is dropped and makes the next run fail. A run
// command (tuser 2) first walks both curves to fix every advance, when both
// hold more than one point: each step of the joint walk reads four points in
// states RD0, RD1 and RD2 and pushes 12 products through the single shared
// multiply-accumulate unit. A second walk then emits the triangles through
// states EMIT0, EMIT1 and EMIT2, waiting in EMIT2 while the output stalls;
// the input is not ready during a run. Error results (failed set, vertices
// zero) pass through the error state and the output register after the run
// command for an empty or overflowed curve or for one point in each curve, or
// at the end of the joint step whose two candidates are both clockwise. After
// every run both curves are empty again; no clearing pass.
module strip_triangulate_two_curves_unit #(
    parameter int MAX_POINTS  = stc_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF,
    parameter int TAG_WIDTH   = stc_pkg::TAG_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // point_index, x_coord, y_coord
    input  logic [stc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [stc_pkg::MODE_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // vertex_first, vertex_second, vertex_third
    output logic [stc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // failed
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

    `include "strip_triangulate_two_curves_unit_assert.svh"

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int TRI_N  = 2 * MAX_POINTS;
    localparam int STEP_W = $clog2(TRI_N);
    localparam int PT_W   = TAG_WIDTH + 2 * COORD_WIDTH;
    localparam int TW     = stc_pkg::TAG_FIELD_W;
    localparam int CFW    = stc_pkg::COORD_FIELD_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [stc_pkg::OP_CNT_W-1:0] OP_LAST =
        stc_pkg::OP_CNT_W'(stc_pkg::OP_COUNT + stc_pkg::UNIT_LAT - 1);
    localparam logic [stc_pkg::OP_CNT_W-1:0] OP_END =
        stc_pkg::OP_CNT_W'(stc_pkg::OP_COUNT);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD0   = 4'd1;
    localparam logic [3:0] ST_RD1   = 4'd2;
    localparam logic [3:0] ST_RD2   = 4'd3;
    localparam logic [3:0] ST_CALC  = 4'd4;
    localparam logic [3:0] ST_EMIT0 = 4'd5;
    localparam logic [3:0] ST_EMIT1 = 4'd6;
    localparam logic [3:0] ST_EMIT2 = 4'd7;
    localparam logic [3:0] ST_ERR   = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b, n_cnt_b;
    logic              r_ovf, n_ovf;
    logic [AW-1:0]     r_ca, n_ca;
    logic [AW-1:0]     r_cb, n_cb;
    logic [STEP_W-1:0] r_step, n_step;
    logic [TRI_N-1:0]  r_dec, n_dec;
    logic [stc_pkg::OP_CNT_W-1:0] r_op, n_op;

    logic [stc_pkg::PT_N-1:0][COORD_WIDTH-1:0] r_px;
    logic [stc_pkg::PT_N-1:0][COORD_WIDTH-1:0] r_py;
    logic [TAG_WIDTH-1:0] r_tag_a;
    logic [TAG_WIDTH-1:0] r_tag_b;

    logic                          r_out_valid;
    logic [stc_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                          r_out_fail;
    logic                          r_out_last;

    logic              in_acc;
    logic              out_free;
    logic              load_out;
    logic              out_err;
    logic              out_last;
    logic              we_a;
    logic              we_b;
    logic [PT_W-1:0]   wdata;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [PT_W-1:0]   rdata_a;
    logic [PT_W-1:0]   rdata_b;
    logic [CNT_W-1:0]  ca_p1;
    logic [CNT_W-1:0]  cb_p1;
    logic [CNT_W-1:0]  ca_p2;
    logic [CNT_W-1:0]  cb_p2;
    logic              more_a;
    logic              more_b;
    logic              adv_calc;
    logic              adv_emit;
    logic              adv_sel;
    logic              nmore_a;
    logic              nmore_b;
    logic [TAG_WIDTH-1:0] third_tag;
    logic              uop_valid;
    stc_pkg::t_uop     uop;
    stc_pkg::t_orient  flags;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign wdata = {TAG_WIDTH'(s_axis_tdata[TW-1:0]),
                    COORD_WIDTH'(s_axis_tdata[TW+CFW-1:TW]),
                    COORD_WIDTH'(s_axis_tdata[TW+2*CFW-1:TW+CFW])};

    assign ca_p1  = CNT_W'(r_ca) + CNT_W'(1);
    assign cb_p1  = CNT_W'(r_cb) + CNT_W'(1);
    assign ca_p2  = ca_p1 + CNT_W'(1);
    assign cb_p2  = cb_p1 + CNT_W'(1);
    assign more_a = ca_p1 < r_cnt_a;
    assign more_b = cb_p1 < r_cnt_b;

    always_comb begin
        if (r_state inside {ST_RD1, ST_EMIT1, ST_EMIT2}) begin
            raddr_a = ca_p1[AW-1:0];
            raddr_b = cb_p1[AW-1:0];
        end else begin
            raddr_a = r_ca;
            raddr_b = r_cb;
        end
    end

    // advance rule of the joint walk
    always_comb begin
        if (flags.abc) begin
            adv_calc = 1'b1;
        end else if (flags.abd) begin
            adv_calc = 1'b0;
        end else if (flags.cbd) begin
            adv_calc = 1'b0;
        end else if (flags.adc) begin
            adv_calc = 1'b1;
        end else begin
            adv_calc = !flags.dlt;
        end
    end

    assign adv_emit  = (more_a && more_b) ? r_dec[r_step] : more_b;
    assign adv_sel   = (r_state == ST_CALC) ? adv_calc : adv_emit;
    assign nmore_a   = adv_sel ? more_a : (ca_p2 < r_cnt_a);
    assign nmore_b   = adv_sel ? (cb_p2 < r_cnt_b) : more_b;
    assign out_last  = !nmore_a && !nmore_b;
    assign third_tag = adv_emit ? rdata_b[PT_W-1:2*COORD_WIDTH]
                                : rdata_a[PT_W-1:2*COORD_WIDTH];

    assign uop_valid = (r_state == ST_CALC) && (r_op < OP_END);
    assign uop       = stc_pkg::uop_rom(r_op);

    always_comb begin
        n_state  = r_state;
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_ovf    = r_ovf;
        n_ca     = r_ca;
        n_cb     = r_cb;
        n_step   = r_step;
        n_dec    = r_dec;
        n_op     = r_op;
        we_a     = 1'b0;
        we_b     = 1'b0;
        load_out = 1'b0;
        out_err  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_axis_tuser)
                        stc_pkg::MODE_LOAD_A: begin
                            if (r_cnt_a < CNT_MAX) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        stc_pkg::MODE_LOAD_B: begin
                            if (r_cnt_b < CNT_MAX) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        stc_pkg::MODE_RUN: begin
                            n_ca   = '0;
                            n_cb   = '0;
                            n_step = '0;
                            if (r_ovf || r_cnt_a == '0 || r_cnt_b == '0 ||
                                (r_cnt_a == CNT_W'(1) && r_cnt_b == CNT_W'(1))) begin
                                n_state = ST_ERR;
                            end else if (r_cnt_a > CNT_W'(1) && r_cnt_b > CNT_W'(1)) begin
                                n_state = ST_RD0;
                            end else begin
                                n_state = ST_EMIT0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD0: begin
                n_state = ST_RD1;
            end
            ST_RD1: begin
                n_state = ST_RD2;
            end
            ST_RD2: begin
                n_op    = '0;
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_op != OP_LAST) begin
                    n_op = r_op + stc_pkg::OP_CNT_W'(1);
                end else if (flags.abc && flags.abd) begin
                    n_state = ST_ERR;
                end else begin
                    n_dec[r_step] = adv_calc;
                    if (adv_calc) begin
                        n_cb = r_cb + AW'(1);
                    end else begin
                        n_ca = r_ca + AW'(1);
                    end
                    if (nmore_a && nmore_b) begin
                        n_step  = r_step + STEP_W'(1);
                        n_state = ST_RD0;
                    end else begin
                        n_ca    = '0;
                        n_cb    = '0;
                        n_step  = '0;
                        n_state = ST_EMIT0;
                    end
                end
            end
            ST_EMIT0: begin
                n_state = ST_EMIT1;
            end
            ST_EMIT1: begin
                n_state = ST_EMIT2;
            end
            ST_EMIT2: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_step   = r_step + STEP_W'(1);
                    if (adv_emit) begin
                        n_cb = r_cb + AW'(1);
                    end else begin
                        n_ca = r_ca + AW'(1);
                    end
                    if (out_last) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_ovf   = 1'b0;
                        n_ca    = '0;
                        n_cb    = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT0;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_err  = 1'b1;
                    n_cnt_a  = '0;
                    n_cnt_b  = '0;
                    n_ovf    = 1'b0;
                    n_ca     = '0;
                    n_cb     = '0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ovf       <= 1'b0;
            r_ca        <= '0;
            r_cb        <= '0;
            r_step      <= '0;
            r_op        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ovf   <= n_ovf;
            r_ca    <= n_ca;
            r_cb    <= n_cb;
            r_step  <= n_step;
            r_op    <= n_op;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
        if (r_state == ST_RD1) begin
            r_px[stc_pkg::PT_A] <= rdata_a[2*COORD_WIDTH-1:COORD_WIDTH];
            r_py[stc_pkg::PT_A] <= rdata_a[COORD_WIDTH-1:0];
            r_px[stc_pkg::PT_B] <= rdata_b[2*COORD_WIDTH-1:COORD_WIDTH];
            r_py[stc_pkg::PT_B] <= rdata_b[COORD_WIDTH-1:0];
        end
        if (r_state == ST_RD2) begin
            r_px[stc_pkg::PT_C] <= rdata_a[2*COORD_WIDTH-1:COORD_WIDTH];
            r_py[stc_pkg::PT_C] <= rdata_a[COORD_WIDTH-1:0];
            r_px[stc_pkg::PT_D] <= rdata_b[2*COORD_WIDTH-1:COORD_WIDTH];
            r_py[stc_pkg::PT_D] <= rdata_b[COORD_WIDTH-1:0];
        end
        if (r_state == ST_EMIT1) begin
            r_tag_a <= rdata_a[PT_W-1:2*COORD_WIDTH];
            r_tag_b <= rdata_b[PT_W-1:2*COORD_WIDTH];
        end
        if (load_out) begin
            r_out_fail <= out_err;
            r_out_last <= out_err || out_last;
            if (out_err) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {TW'(third_tag), TW'(r_tag_b), TW'(r_tag_a)};
            end
        end
    end

    stc_point_ram #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (AW),
        .DATA_W (PT_W)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    stc_point_ram #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (AW),
        .DATA_W (PT_W)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    stc_area_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_area (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_px        (r_px),
        .i_py        (r_py),
        .i_uop_valid (uop_valid),
        .i_uop       (uop),
        .o_flags     (flags)
    );

    assign s_axis_tready   = (r_state == ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_fail;
    assign m_axis_tlast    = r_out_last;

    // error results carry no vertices and close the run
    `STC_ASSERT_NOW(a_fail_zero, m_axis_tvalid && m_axis_tuser[0],
                    m_axis_tdata == '0 && m_axis_tlast)

    // a run with an empty curve goes straight to the error result
    `STC_ASSERT_NEXT(a_empty_err,
                     in_acc && s_axis_tuser == stc_pkg::MODE_RUN &&
                     (r_cnt_a == '0 || r_cnt_b == '0),
                     r_state == ST_ERR)

    // walk cursors stay on loaded points
    `STC_ASSERT_NOW(a_cursor_range,
                    r_state == ST_RD0 || r_state == ST_EMIT0 || r_state == ST_EMIT2,
                    CNT_W'(r_ca) < r_cnt_a && CNT_W'(r_cb) < r_cnt_b)

endmodule
